// File: rtl/pds_pkg.sv
package pds_pkg;

  localparam int REF_W = 30;
  localparam int TGT_W = 32;
  localparam int OUT_W = 31;
  localparam int VCO_W = TGT_W + 3;
  localparam int R_W   = 25;
  localparam int CM_W  = 6;
  localparam int CN_W  = 6;
  localparam int CO_W  = 2;
  localparam int CNT_W = 4;

  localparam int unsigned REF_RESET_HZ  = 24000000;
  localparam int unsigned VCO_MAX_HZ    = 1500000000;
  localparam int unsigned REFDIV_MIN_HZ = 24000000;
  localparam int unsigned REFDIV_MAX_HZ = 30000000;
  localparam int unsigned CM_LOWEST     = 16;
  localparam int unsigned CN_HIGHEST    = 32;
  localparam int unsigned CO_HIGHEST    = 3;
  localparam int unsigned VCO_MIN_HZ    = REFDIV_MIN_HZ * CM_LOWEST;

  localparam int R_DIV_STEPS = REF_W / 2;
  localparam int M_DIV_STEPS = CM_W / 2;

  typedef struct packed {
    logic load;
    logic co_inc;
    logic cn_init;
    logic cn_inc;
    logic div_start_r;
    logic div_start_m;
    logic div_step;
    logic eval;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic vco_low;
    logic vco_high;
    logic co_last;
    logic cn_last;
    logic div_last;
    logic r_high;
    logic r_low;
    logic hit;
  } flags_t;

endpackage

// File: rtl/pds_datapath.sv
module pds_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pds_pkg::REF_W-1:0]     cfg_data,
  input  logic [pds_pkg::TGT_W-1:0]     target_in,
  input  pds_pkg::cmd_t                 cmd,
  output pds_pkg::flags_t               sts,
  output logic [pds_pkg::OUT_W-1:0]     best_out
);

  logic [pds_pkg::REF_W-1:0] ref_clk;
  logic [pds_pkg::TGT_W-1:0] target;
  logic [pds_pkg::CO_W-1:0]  co;
  logic [pds_pkg::CN_W-1:0]  cn;
  logic [pds_pkg::REF_W-1:0] rem;
  logic [31:0]               quo;
  logic [pds_pkg::REF_W-1:0] divisor;
  logic [pds_pkg::CNT_W-1:0] count;
  logic [pds_pkg::R_W-1:0]   r_val;
  logic [pds_pkg::OUT_W-1:0] best;
  logic                      found;

  logic [pds_pkg::VCO_W-1:0] vco;
  logic [pds_pkg::REF_W-1:0] r_quo;
  logic [30:0]               dvd;
  logic [pds_pkg::CM_W-1:0]  cm;
  logic                      cm_ok;
  logic [30:0]               prod;
  logic [30:0]               cand;
  logic                      better;
  logic [61:0]               step1;
  logic [61:0]               step2;

  function automatic logic [61:0] div_bit(input logic [29:0] rem_in,
                                          input logic [31:0] quo_in,
                                          input logic [29:0] dsr);
    logic [30:0] sh;
    logic        ge;
    logic [30:0] diff;
    sh   = {rem_in, quo_in[31]};
    ge   = sh >= {1'b0, dsr};
    diff = sh - {1'b0, dsr};
    return {(ge ? diff[29:0] : sh[29:0]), quo_in[30:0], ge};
  endfunction

  always_comb begin
    vco         = {3'b000, target} << co;
    sts.vco_low  = vco < pds_pkg::VCO_W'(pds_pkg::VCO_MIN_HZ);
    sts.vco_high = vco > pds_pkg::VCO_W'(pds_pkg::VCO_MAX_HZ);
    sts.co_last  = co == pds_pkg::CO_W'(pds_pkg::CO_HIGHEST);
    sts.cn_last  = cn == pds_pkg::CN_W'(pds_pkg::CN_HIGHEST);
    sts.div_last = count == pds_pkg::CNT_W'(1);
    r_quo        = quo[pds_pkg::REF_W-1:0];
    sts.r_high   = r_quo > pds_pkg::REF_W'(pds_pkg::REFDIV_MAX_HZ);
    sts.r_low    = r_quo < pds_pkg::REF_W'(pds_pkg::REFDIV_MIN_HZ);
    dvd          = vco[30:0] + 31'(r_quo) - 31'd1;
    cm           = quo[pds_pkg::CM_W-1:0];
    cm_ok        = cm >= pds_pkg::CM_W'(pds_pkg::CM_LOWEST);
    prod         = {6'b0, r_val} * {25'b0, cm};
    cand         = prod >> co;
    sts.hit      = cm_ok && ({1'b0, cand} == target);
    better       = cm_ok && ({1'b0, cand} >= target) && (!found || cand < best);
    step1        = div_bit(rem, quo, divisor);
    step2        = div_bit(step1[61:32], step1[31:0], divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clk <= pds_pkg::REF_W'(pds_pkg::REF_RESET_HZ);
    end else if (cfg_write) begin
      ref_clk <= cfg_data;
    end
    if (cmd.load) begin
      target <= target_in;
      co     <= '0;
      best   <= '0;
      found  <= 1'b0;
    end
    if (cmd.co_inc) begin
      co <= co + 1'b1;
    end
    if (cmd.cn_init) begin
      cn <= pds_pkg::CN_W'(1);
    end
    if (cmd.cn_inc) begin
      cn <= cn + 1'b1;
    end
    if (cmd.div_start_r) begin
      rem     <= '0;
      quo     <= {ref_clk, 2'b00};
      divisor <= pds_pkg::REF_W'(cn);
      count   <= pds_pkg::CNT_W'(pds_pkg::R_DIV_STEPS);
    end
    if (cmd.div_start_m) begin
      r_val   <= r_quo[pds_pkg::R_W-1:0];
      rem     <= pds_pkg::REF_W'(dvd[30:6]);
      quo     <= {dvd[5:0], 26'b0};
      divisor <= r_quo;
      count   <= pds_pkg::CNT_W'(pds_pkg::M_DIV_STEPS);
    end
    if (cmd.div_step) begin
      rem   <= step2[61:32];
      quo   <= step2[31:0];
      count <= count - 1'b1;
    end
    if (cmd.eval && better) begin
      best  <= cand;
      found <= 1'b1;
    end
    if (cmd.out_load) begin
      best_out <= best;
    end
  end

endmodule

// File: rtl/pds_ctrl.sv
module pds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pds_pkg::flags_t   sts,
  output pds_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    IDLE,
    CO_CHK,
    CN_START,
    DIV_R,
    R_CHK,
    DIV_M,
    EVAL,
    NEXT_CN,
    NEXT_CO,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CO_CHK;
        end
      end
      CO_CHK: begin
        if (sts.vco_low) begin
          state_next = NEXT_CO;
        end else if (sts.vco_high) begin
          state_next = FINISH;
        end else begin
          cmd.cn_init = 1'b1;
          state_next  = CN_START;
        end
      end
      CN_START: begin
        cmd.div_start_r = 1'b1;
        state_next      = DIV_R;
      end
      DIV_R: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = R_CHK;
        end
      end
      R_CHK: begin
        if (sts.r_high) begin
          state_next = NEXT_CN;
        end else if (sts.r_low) begin
          state_next = NEXT_CO;
        end else begin
          cmd.div_start_m = 1'b1;
          state_next      = DIV_M;
        end
      end
      DIV_M: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = EVAL;
        end
      end
      EVAL: begin
        cmd.eval   = 1'b1;
        state_next = sts.hit ? FINISH : NEXT_CN;
      end
      NEXT_CN: begin
        if (sts.cn_last) begin
          state_next = NEXT_CO;
        end else begin
          cmd.cn_inc = 1'b1;
          state_next = CN_START;
        end
      end
      NEXT_CO: begin
        if (sts.co_last) begin
          state_next = FINISH;
        end else begin
          cmd.co_inc = 1'b1;
          state_next = CO_CHK;
        end
      end
      FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/pll_divider_search.sv
// The search runs from the input beat to the result, plus any wait for out_ready
// to free the output register; each divider pair evaluated takes a reference/CN
// division and a multiplier division, and one rejected on the reference window
// takes only the first. The serial divider, two quotient bits a cycle, sets the pace.
// Throughput: one beat in flight; the next input is taken once the result sits
// in the output register. Reset: rst clears control and output valid and loads
// a 24 MHz reference clock.
module pll_divider_search (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pds_pkg::TGT_W-1:0] target_frequency_hz,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pds_pkg::OUT_W-1:0] best_frequency_hz,
  input  logic                      cfg_write,
  input  logic [pds_pkg::REF_W-1:0] reference_clock_hz
);

  pds_pkg::cmd_t    cmd;
  pds_pkg::flags_t  sts;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pds_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (reference_clock_hz),
    .target_in (target_frequency_hz),
    .cmd       (cmd),
    .sts       (sts),
    .best_out  (best_frequency_hz)
  );

`ifndef NO_ASSERTIONS
  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.co_inc, cmd.cn_init, cmd.cn_inc, cmd.div_start_r,
              cmd.div_start_m, cmd.div_step, cmd.eval, cmd.out_load}))
    else $error("more than one datapath command issued");

  a_eval_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> $past(cmd.div_step) && $past(sts.div_last))
    else $error("evaluation without a finished multiplier division");

  a_m_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start_m |-> !sts.r_high && !sts.r_low)
    else $error("multiplier division started outside the reference window");

  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a search is running");
`endif

endmodule
